// ===== design/box_muller_gaussian_macros.svh =====
// ----------------------------------------------------------------------------
// box muller gaussian assertion macros
// same-cycle and next-cycle implication checks, clocked on clk, reset arst_n
// ----------------------------------------------------------------------------
`ifndef BOX_MULLER_GAUSSIAN_MACROS_SVH
`define BOX_MULLER_GAUSSIAN_MACROS_SVH
`ifndef SYNTH
`define BMG_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("bmg same-cycle check failed");
`define BMG_ASSERT_NXT(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("bmg next-cycle check failed");
`else
`define BMG_ASSERT_IMP(lbl, ante, cons)
`define BMG_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/bmg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmg_pkg
// constants, stage payload types and helper functions of the normal generator
// ----------------------------------------------------------------------------
package bmg_pkg;

	localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
	localparam logic [31:0] TWO_LN2_Q28 = 32'd372130559;
	localparam logic [31:0] PI4_Q30     = 32'd843314857;

	// floor(y / d) for y < 2^31 as (y * ceil(2^s / d)) >> s, s = 31 + ceil(log2 d)
	localparam int unsigned SH_72 = 38;
	localparam int unsigned SH_42 = 37;
	localparam int unsigned SH_20 = 36;
	localparam int unsigned SH_6  = 34;
	localparam int unsigned SH_90 = 38;
	localparam int unsigned SH_56 = 37;
	localparam int unsigned SH_30 = 36;
	localparam int unsigned SH_12 = 35;
	localparam logic [31:0] RCP_72 = 32'(((64'd1 << SH_72) + 64'd71) / 64'd72);
	localparam logic [31:0] RCP_42 = 32'(((64'd1 << SH_42) + 64'd41) / 64'd42);
	localparam logic [31:0] RCP_20 = 32'(((64'd1 << SH_20) + 64'd19) / 64'd20);
	localparam logic [31:0] RCP_6  = 32'(((64'd1 << SH_6) + 64'd5) / 64'd6);
	localparam logic [31:0] RCP_90 = 32'(((64'd1 << SH_90) + 64'd89) / 64'd90);
	localparam logic [31:0] RCP_56 = 32'(((64'd1 << SH_56) + 64'd55) / 64'd56);
	localparam logic [31:0] RCP_30 = 32'(((64'd1 << SH_30) + 64'd29) / 64'd30);
	localparam logic [31:0] RCP_12 = 32'(((64'd1 << SH_12) + 64'd11) / 64'd12);

	typedef struct packed {
		logic [31:0] m;
		logic [31:0] frac;
		logic [5:0]  e;
		logic [31:0] angle;
	} bmg_log_t;

	typedef struct packed {
		logic [62:0] rem;
		logic [62:0] root;
		logic [31:0] angle;
	} bmg_sqrt_t;

	typedef struct packed {
		logic [29:0] x;
		logic [29:0] x2;
		logic [30:0] hs;
		logic [30:0] hc;
		logic [31:0] radius;
		logic [1:0]  quad;
		logic        oct;
	} bmg_trig_t;

	function automatic logic [30:0] div_rcp(input logic [30:0] y, input logic [31:0] mul,
			input int unsigned sh);
		logic [63:0] pr;
		pr = 64'(y) * 64'(mul);
		return 31'(pr >> sh);
	endfunction

	// log2(2^w + 1) in Q.32, evaluated at elaboration
	function automatic logic [37:0] log2_pow2p1(input int unsigned w);
		logic [63:0] m;
		logic [31:0] frac;
		frac = '0;
		if (w > 31) begin
			m = ((64'd1 << w) + 64'd1) >> (w - 31);
		end else begin
			m = ((64'd1 << w) + 64'd1) << (31 - w);
		end
		for (int i = 31; i >= 0; i--) begin
			m = (m * m) >> 31;
			if (m[32]) begin
				frac[i] = 1'b1;
				m = m >> 1;
			end
		end
		return {6'(w), frac};
	endfunction

endpackage
`default_nettype wire

// ===== design/bmg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmg channel interfaces
// uniform word pair in, normal sample out, valid/ready handshake
// ----------------------------------------------------------------------------
interface bmg_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] uniform_a;
	logic [31:0] uniform_b;
	modport source(output valid, uniform_a, uniform_b, input ready);
	modport sink(input valid, uniform_a, uniform_b, output ready);
endinterface

interface bmg_out_if #(parameter int SAMPLE_BITS = 16);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic                          last;
	modport source(output valid, sample, last, input ready);
	modport sink(input valid, sample, last, output ready);
endinterface
`default_nettype wire

// ===== design/box_muller_gaussian.sv =====
`default_nettype none
`include "box_muller_gaussian_macros.svh"
// ----------------------------------------------------------------------------
// box_muller_gaussian
// Box-Muller normal generator: one uniform word pair in, sine and cosine
// samples out. Every request of two uniform words gives two Q3.12 samples,
// first the sine sample, then the cosine sample with last set. The datapath is
// a fixed pipeline (input and normalize stages, 32 log2 squaring cells, radius
// scaling, 32 square-root cells, angle and horner stages, product and rounding).
// The output register hands out one sample a cycle while the sink is ready,
// and the block takes a new request only while that register is empty or
// hands over its cosine sample; while the sink stalls the whole pipeline holds.
// ----------------------------------------------------------------------------
module box_muller_gaussian #(
	parameter int UNIFORM_BITS  = 32,
	parameter int SAMPLE_BITS   = 16,
	parameter int FRACTION_BITS = 12
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bmg_in_if.sink     uniform,
	bmg_out_if.source  normal
);
	import bmg_pkg::*;

	localparam int          XW      = UNIFORM_BITS + 1;
	localparam int          RND_SH  = 58 - FRACTION_BITS;
	localparam logic [37:0] LOG_TOP = log2_pow2p1(UNIFORM_BITS);
	localparam logic [63:0] LIM_POS = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;

	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;
	localparam logic [1:0] QUAD_IV  = 2'd3;

	function automatic logic [SAMPLE_BITS-1:0] to_sample(input logic [62:0] pr,
			input logic neg);
		logic [63:0] v;
		v = (64'(pr) + (64'd1 << (RND_SH - 1))) >> RND_SH;
		if (!neg) begin
			if (v > LIM_POS) v = LIM_POS;
			return SAMPLE_BITS'(v);
		end
		if (v > LIM_POS + 64'd1) v = LIM_POS + 64'd1;
		return SAMPLE_BITS'(64'd0 - v);
	endfunction

	logic en;

	// front: a + 1, angle word, leading-one position, normalize
	logic [XW-1:0] x_s1;
	logic [31:0]   p_s1;
	logic          v_s1;
	logic [5:0]    e_c;
	logic [XW-1:0] x_s2;
	logic [5:0]    e_s2;
	logic [31:0]   p_s2;
	logic          v_s2;
	logic [63:0]   xw_c;

	bmg_log_t  lg   [0:32];
	logic      lg_v [0:32];

	logic [37:0] lb_c;
	logic [33:0] dq_s4;
	logic [31:0] p_s4;
	logic        v_s4;
	logic [63:0] r2p_c;

	bmg_sqrt_t sq   [0:32];
	logic      sq_v [0:32];

	// angle path
	logic [31:0] ang_c;
	logic [29:0] t_s6;
	logic [1:0]  quad_s6;
	logic        oct_s6;
	logic [31:0] rad_s6;
	logic        v_s6;
	logic [29:0] x_s7;
	logic [1:0]  quad_s7;
	logic        oct_s7;
	logic [31:0] rad_s7;
	logic        v_s7;
	logic [29:0] x_s8;
	logic [29:0] x2_s8;
	logic [1:0]  quad_s8;
	logic        oct_s8;
	logic [31:0] rad_s8;
	logic        v_s8;

	bmg_trig_t tr   [0:3];
	logic      tr_v [0:3];

	logic [30:0] s_s10;
	logic [30:0] pc_s10;
	logic [31:0] rad_s10;
	logic [1:0]  quad_s10;
	logic        oct_s10;
	logic        v_s10;
	logic [30:0] s_s11;
	logic [30:0] c_s11;
	logic [31:0] rad_s11;
	logic [1:0]  quad_s11;
	logic        oct_s11;
	logic        v_s11;

	logic [30:0] sr_c;
	logic [30:0] cr_c;
	logic [30:0] smag_c;
	logic [30:0] cmag_c;
	logic        sneg_c;
	logic        cneg_c;
	logic [62:0] ps_s12;
	logic [62:0] pc_s12;
	logic        sneg_s12;
	logic        cneg_s12;
	logic        v_s12;

	logic [SAMPLE_BITS-1:0] sin_q;
	logic [SAMPLE_BITS-1:0] cos_q;
	logic                   out_v_q;
	logic                   phase_q;

	// the pipeline moves when the output register is empty or hands over its cosine
	assign en            = !out_v_q || (phase_q && normal.ready);
	assign uniform.ready = en;

	always_comb begin
		e_c = '0;
		for (int i = 0; i < XW; i++) begin
			if (x_s1[i]) e_c = 6'(i);
		end
	end

	assign xw_c = 64'(x_s2) << 31;
	assign lb_c = {lg[32].e, lg[32].frac};
	assign r2p_c = 64'(dq_s4) * 64'(TWO_LN2_Q28);
	assign ang_c = sq[32].angle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			lg_v[0]  <= 1'b0;
			v_s4     <= 1'b0;
			sq_v[0]  <= 1'b0;
			v_s6     <= 1'b0;
			v_s7     <= 1'b0;
			v_s8     <= 1'b0;
			tr_v[0]  <= 1'b0;
			v_s10    <= 1'b0;
			v_s11    <= 1'b0;
			v_s12    <= 1'b0;
			out_v_q  <= 1'b0;
		end else if (en) begin
			v_s1     <= uniform.valid;
			v_s2     <= v_s1;
			lg_v[0]  <= v_s2;
			v_s4     <= lg_v[32];
			sq_v[0]  <= v_s4;
			v_s6     <= sq_v[32];
			v_s7     <= v_s6;
			v_s8     <= v_s7;
			tr_v[0]  <= v_s8;
			v_s10    <= tr_v[3];
			v_s11    <= v_s10;
			v_s12    <= v_s11;
			out_v_q  <= v_s12;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (en) begin
			phase_q <= 1'b0;
		end else if (normal.valid && normal.ready) begin
			phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= XW'(uniform.uniform_a[UNIFORM_BITS-1:0]) + XW'(1);
			p_s1 <= 32'(uniform.uniform_b[UNIFORM_BITS-1:0]) << (32 - UNIFORM_BITS);

			x_s2 <= x_s1;
			e_s2 <= e_c;
			p_s2 <= p_s1;

			lg[0].m     <= 32'(xw_c >> e_s2);
			lg[0].frac  <= '0;
			lg[0].e     <= e_s2;
			lg[0].angle <= p_s2;

			dq_s4 <= (LOG_TOP > lb_c) ? 34'((LOG_TOP - lb_c) >> 4) : '0;
			p_s4  <= lg[32].angle;

			sq[0].rem   <= {r2p_c[62:28], 28'd0};
			sq[0].root  <= '0;
			sq[0].angle <= p_s4;

			t_s6    <= ang_c[29] ? (30'h2000_0000 - 30'(ang_c[28:0])) : 30'(ang_c[28:0]);
			quad_s6 <= ang_c[31:30];
			oct_s6  <= ang_c[29];
			rad_s6  <= sq[32].root[31:0];

			x_s7    <= 30'((64'(t_s6) * 64'(PI4_Q30)) >> 29);
			quad_s7 <= quad_s6;
			oct_s7  <= oct_s6;
			rad_s7  <= rad_s6;

			x_s8    <= x_s7;
			x2_s8   <= 30'((64'(x_s7) * 64'(x_s7)) >> 30);
			quad_s8 <= quad_s7;
			oct_s8  <= oct_s7;
			rad_s8  <= rad_s7;

			tr[0].x      <= x_s8;
			tr[0].x2     <= x2_s8;
			tr[0].hs     <= Q30_ONE - div_rcp(31'(x2_s8), RCP_72, SH_72);
			tr[0].hc     <= Q30_ONE - div_rcp(31'(x2_s8), RCP_90, SH_90);
			tr[0].radius <= rad_s8;
			tr[0].quad   <= quad_s8;
			tr[0].oct    <= oct_s8;

			s_s10    <= 31'((64'(tr[3].x) * 64'(tr[3].hs)) >> 30);
			pc_s10   <= 31'((64'(tr[3].x2) * 64'(tr[3].hc)) >> 30);
			rad_s10  <= tr[3].radius;
			quad_s10 <= tr[3].quad;
			oct_s10  <= tr[3].oct;

			s_s11    <= s_s10;
			c_s11    <= Q30_ONE - (pc_s10 >> 1);
			rad_s11  <= rad_s10;
			quad_s11 <= quad_s10;
			oct_s11  <= oct_s10;

			ps_s12   <= 63'(64'(rad_s11) * 64'(smag_c));
			pc_s12   <= 63'(64'(rad_s11) * 64'(cmag_c));
			sneg_s12 <= sneg_c;
			cneg_s12 <= cneg_c;

			sin_q <= to_sample(ps_s12, sneg_s12);
			cos_q <= to_sample(pc_s12, cneg_s12);
		end
	end

	// octant and quadrant symmetry
	always_comb begin
		sr_c = oct_s11 ? c_s11 : s_s11;
		cr_c = oct_s11 ? s_s11 : c_s11;
		unique case (quad_s11)
			QUAD_I: begin
				smag_c = sr_c; sneg_c = 1'b0; cmag_c = cr_c; cneg_c = 1'b0;
			end
			QUAD_II: begin
				smag_c = cr_c; sneg_c = 1'b0; cmag_c = sr_c; cneg_c = 1'b1;
			end
			QUAD_III: begin
				smag_c = sr_c; sneg_c = 1'b1; cmag_c = cr_c; cneg_c = 1'b1;
			end
			QUAD_IV: begin
				smag_c = cr_c; sneg_c = 1'b1; cmag_c = sr_c; cneg_c = 1'b0;
			end
			default: begin
				smag_c = sr_c; sneg_c = 1'b0; cmag_c = cr_c; cneg_c = 1'b0;
			end
		endcase
	end

	for (genvar k = 0; k < 32; k++) begin : g_log
		bmg_log_cell #(.BIT(31 - k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.up_valid (lg_v[k]),
			.up       (lg[k]),
			.dn_valid (lg_v[k+1]),
			.dn       (lg[k+1])
		);
	end

	for (genvar k = 0; k < 32; k++) begin : g_sqrt
		bmg_sqrt_cell #(.STEP(k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.up_valid (sq_v[k]),
			.up       (sq[k]),
			.dn_valid (sq_v[k+1]),
			.dn       (sq[k+1])
		);
	end

	bmg_horner_cell #(
		.SIN_MUL (RCP_42), .SIN_SH (SH_42), .COS_MUL (RCP_56), .COS_SH (SH_56)
	) u_horner0 (
		.clk (clk), .arst_n (arst_n), .en (en),
		.up_valid (tr_v[0]), .up (tr[0]), .dn_valid (tr_v[1]), .dn (tr[1])
	);

	bmg_horner_cell #(
		.SIN_MUL (RCP_20), .SIN_SH (SH_20), .COS_MUL (RCP_30), .COS_SH (SH_30)
	) u_horner1 (
		.clk (clk), .arst_n (arst_n), .en (en),
		.up_valid (tr_v[1]), .up (tr[1]), .dn_valid (tr_v[2]), .dn (tr[2])
	);

	bmg_horner_cell #(
		.SIN_MUL (RCP_6), .SIN_SH (SH_6), .COS_MUL (RCP_12), .COS_SH (SH_12)
	) u_horner2 (
		.clk (clk), .arst_n (arst_n), .en (en),
		.up_valid (tr_v[2]), .up (tr[2]), .dn_valid (tr_v[3]), .dn (tr[3])
	);

	assign normal.valid  = out_v_q;
	assign normal.sample = phase_q ? cos_q : sin_q;
	assign normal.last   = phase_q;

	`BMG_ASSERT_IMP(a_last_has_data, phase_q, out_v_q)
	`BMG_ASSERT_NXT(a_cos_follows, normal.valid && normal.ready && !phase_q, normal.valid && phase_q)
	`BMG_ASSERT_NXT(a_pair_wraps, normal.valid && normal.ready && phase_q, !phase_q)
	`BMG_ASSERT_IMP(a_hold_busy, out_v_q && !(phase_q && normal.ready), !uniform.ready)
endmodule
`default_nettype wire

// ===== design/bmg_log_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmg_log_cell
// one squaring step of the log2 mantissa, yields one fraction bit
// ----------------------------------------------------------------------------
module bmg_log_cell #(
	parameter int BIT = 31
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              up_valid,
	input  wire bmg_pkg::bmg_log_t up,
	output logic                   dn_valid,
	output bmg_pkg::bmg_log_t      dn
);
	import bmg_pkg::*;

	logic [63:0] sq;
	logic [32:0] nx;
	bmg_log_t    nxt;
	bmg_log_t    cell_q;
	logic        valid_q;

	always_comb begin
		sq  = 64'(up.m) * 64'(up.m);
		nx  = sq[63:31];
		nxt = up;
		if (nx[32]) begin
			nxt.frac[BIT] = 1'b1;
			nxt.m         = nx[32:1];
		end else begin
			nxt.m = nx[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn       = cell_q;
endmodule
`default_nettype wire

// ===== design/bmg_sqrt_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmg_sqrt_cell
// one restoring step of the integer square root, two radicand bits per cell
// ----------------------------------------------------------------------------
module bmg_sqrt_cell #(
	parameter int STEP = 0
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               up_valid,
	input  wire bmg_pkg::bmg_sqrt_t up,
	output logic                    dn_valid,
	output bmg_pkg::bmg_sqrt_t      dn
);
	import bmg_pkg::*;

	localparam logic [62:0] BIT_W = 63'(64'd1 << (62 - 2 * STEP));

	logic [63:0] trial;
	bmg_sqrt_t   nxt;
	bmg_sqrt_t   cell_q;
	logic        valid_q;

	always_comb begin
		trial     = 64'(up.root) + 64'(BIT_W);
		nxt       = up;
		if (64'(up.rem) >= trial) begin
			nxt.rem  = up.rem - trial[62:0];
			nxt.root = (up.root >> 1) + BIT_W;
		end else begin
			nxt.root = up.root >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn       = cell_q;
endmodule
`default_nettype wire

// ===== design/bmg_horner_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bmg_horner_cell
// one horner step of the sine and cosine series: h = 1 - x^2 * h / k
// ----------------------------------------------------------------------------
module bmg_horner_cell #(
	parameter logic [31:0] SIN_MUL = 32'd1,
	parameter int unsigned SIN_SH  = 32,
	parameter logic [31:0] COS_MUL = 32'd1,
	parameter int unsigned COS_SH  = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               up_valid,
	input  wire bmg_pkg::bmg_trig_t up,
	output logic                    dn_valid,
	output bmg_pkg::bmg_trig_t      dn
);
	import bmg_pkg::*;

	bmg_trig_t   d_s1;
	logic [30:0] ps_s1;
	logic [30:0] pc_s1;
	logic        v_s1;
	bmg_trig_t   d_nx;
	bmg_trig_t   d_s2;
	logic        v_s2;

	always_comb begin
		d_nx    = d_s1;
		d_nx.hs = Q30_ONE - div_rcp(ps_s1, SIN_MUL, SIN_SH);
		d_nx.hc = Q30_ONE - div_rcp(pc_s1, COS_MUL, COS_SH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= up_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1  <= up;
			ps_s1 <= 31'((64'(up.x2) * 64'(up.hs)) >> 30);
			pc_s1 <= 31'((64'(up.x2) * 64'(up.hc)) >> 30);
			d_s2  <= d_nx;
		end
	end

	assign dn_valid = v_s2;
	assign dn       = d_s2;
endmodule
`default_nettype wire

// ===== bench/box_muller_gaussian_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// box_muller_gaussian_tb
// Self-checking bench for the Box-Muller normal generator. A short table of
// directed uniform pairs is followed by about 600 random pairs. The sender
// idles in random bursts and the sink stalls on its own pattern. Every request
// save the typed directed rows runs through the fixed-point integer model, and
// each output sample is checked in order against the queued predictions.
// ----------------------------------------------------------------------------
module box_muller_gaussian_tb;

	localparam int UNIFORM_BITS  = 32;
	localparam int SAMPLE_BITS   = 16;
	localparam int FRACTION_BITS = 12;
	localparam int N_RANDOM      = 600;
	localparam int IDLE_LIMIT    = 4000;
	localparam int DRAIN_CYCLES  = 120;

	localparam logic [63:0] Q30_ONE_W = 64'd1 << 30;
	localparam logic [63:0] LN2X2_Q28 = 64'd372130559;
	localparam logic [63:0] QPI_Q30   = 64'd843314857;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          last;
	} normal_sample_t;

	typedef struct {
		logic [31:0]                   a;
		logic [31:0]                   b;
		bit                            typed;
		logic signed [SAMPLE_BITS-1:0] sin_val;
		logic signed [SAMPLE_BITS-1:0] cos_val;
	} pair_row_t;

	logic clk;
	logic arst_n;

	bmg_in_if                        uin();
	bmg_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) uout();

	box_muller_gaussian #(
		.UNIFORM_BITS (UNIFORM_BITS),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.uniform(uin.sink),
		.normal (uout.source)
	);

	normal_sample_t samples_due[$];
	int             n_errors;
	int             idle_cycles;
	int             cycle;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// ---------------- integer model of the datapath ----------------

	function automatic logic [63:0] log2_fixed(input logic [63:0] x);
		logic [63:0] m;
		logic [63:0] frac;
		int          e;
		bit          found;
		frac  = '0;
		e     = 0;
		found = 0;
		if (x == 0)
			x = 1;
		for (int i = 63; i >= 0; i--) begin
			if (!found && x[i]) begin
				e     = i;
				found = 1;
			end
		end
		if (e > 31)
			m = x >> (e - 31);
		else
			m = x << (31 - e);
		for (int i = 31; i >= 0; i--) begin
			m = (m * m) >> 31;
			if (m >= (64'd1 << 32)) begin
				frac[i] = 1'b1;
				m       = m >> 1;
			end
		end
		return (64'(e) << 32) | frac;
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] n);
		logic [63:0] res;
		logic [63:0] bitv;
		res  = '0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n   = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] horner(input logic [63:0] x2, input logic [63:0] h,
			input logic [63:0] dv);
		return Q30_ONE_W - ((x2 * h) >> 30) / dv;
	endfunction

	// t is the angle inside one octant, Q.29 fraction of pi/4
	task automatic trig_octant(input logic [63:0] t, output logic [63:0] s,
			output logic [63:0] c);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] h;
		x  = (t * QPI_Q30) >> 29;
		x2 = (x * x) >> 30;
		h  = Q30_ONE_W - x2 / 72;
		h  = horner(x2, h, 42);
		h  = horner(x2, h, 20);
		h  = horner(x2, h, 6);
		s  = (x * h) >> 30;
		h  = Q30_ONE_W - x2 / 90;
		h  = horner(x2, h, 56);
		h  = horner(x2, h, 30);
		h  = horner(x2, h, 12);
		h  = horner(x2, h, 2);
		c  = h;
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] round_sat(input logic [63:0] radius,
			input logic [63:0] mag, input bit neg);
		logic [63:0] v;
		logic [63:0] lim;
		lim = (64'd1 << (SAMPLE_BITS - 1)) - 1;
		v   = (radius * mag + (64'd1 << (58 - FRACTION_BITS - 1))) >> (58 - FRACTION_BITS);
		if (!neg) begin
			if (v > lim)
				v = lim;
			return SAMPLE_BITS'(v);
		end
		if (v > lim + 1)
			v = lim + 1;
		return SAMPLE_BITS'(64'd0 - v);
	endfunction

	task automatic predict_normal_pair(input logic [31:0] ua, input logic [31:0] ub,
			output logic signed [SAMPLE_BITS-1:0] sin_s,
			output logic signed [SAMPLE_BITS-1:0] cos_s);
		logic [63:0] wmask;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] la;
		logic [63:0] lb;
		logic [63:0] d;
		logic [63:0] r2;
		logic [63:0] radius;
		logic [63:0] p;
		logic [63:0] f;
		logic [63:0] so;
		logic [63:0] co;
		logic [63:0] sr;
		logic [63:0] cr;
		logic [63:0] smag;
		logic [63:0] cmag;
		logic [1:0]  quad;
		bit          sneg;
		bit          cneg;
		wmask  = (64'd1 << UNIFORM_BITS) - 1;
		a      = 64'(ua) & wmask;
		b      = 64'(ub) & wmask;
		la     = log2_fixed((64'd1 << UNIFORM_BITS) + 1);
		lb     = log2_fixed(a + 1);
		d      = (la > lb) ? la - lb : 64'd0;
		r2     = ((d >> 4) * LN2X2_Q28) >> 28;
		radius = int_sqrt(r2 << 28);
		p      = (b << (32 - UNIFORM_BITS)) & 64'hFFFF_FFFF;
		quad   = p[31:30];
		f      = p & ((64'd1 << 29) - 1);
		if (!p[29]) begin
			trig_octant(f, so, co);
			sr = so;
			cr = co;
		end else begin
			trig_octant((64'd1 << 29) - f, so, co);
			sr = co;
			cr = so;
		end
		case (quad)
			2'd0: begin smag = sr; sneg = 0; cmag = cr; cneg = 0; end
			2'd1: begin smag = cr; sneg = 0; cmag = sr; cneg = 1; end
			2'd2: begin smag = sr; sneg = 1; cmag = cr; cneg = 1; end
			default: begin smag = cr; sneg = 1; cmag = sr; cneg = 0; end
		endcase
		sin_s = round_sat(radius, smag, sneg);
		cos_s = round_sat(radius, cmag, cneg);
	endtask

	// ---------------- directed table ----------------

	// a of all ones gives u = 2^32/(2^32+1): the log difference floors at zero
	pair_row_t directed[] = '{
		'{32'hFFFF_FFFF, 32'h0000_0000, 1, 16'sd0, 16'sd0},
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 16'sd0, 16'sd0},
		'{32'hFFFF_FFFF, 32'h8000_0000, 1, 16'sd0, 16'sd0},
		'{32'hFFFF_FFFF, 32'h6000_0000, 1, 16'sd0, 16'sd0},
		'{32'h0000_0000, 32'h0000_0000, 0, 16'sd0, 16'sd0},
		'{32'h0000_0000, 32'h2000_0000, 0, 16'sd0, 16'sd0},
		'{32'h0000_0000, 32'h1FFF_FFFF, 0, 16'sd0, 16'sd0},
		'{32'h0000_0000, 32'h2000_0001, 0, 16'sd0, 16'sd0},
		'{32'h0000_0000, 32'h4000_0000, 0, 16'sd0, 16'sd0},
		'{32'h0000_0000, 32'h8000_0000, 0, 16'sd0, 16'sd0},
		'{32'h0000_0000, 32'hC000_0000, 0, 16'sd0, 16'sd0},
		'{32'h0000_0000, 32'hE000_0000, 0, 16'sd0, 16'sd0},
		'{32'h0000_0000, 32'hFFFF_FFFF, 0, 16'sd0, 16'sd0},
		'{32'h0000_0001, 32'h1234_5678, 0, 16'sd0, 16'sd0},
		'{32'hFFFF_FFFE, 32'h9ABC_DEF0, 0, 16'sd0, 16'sd0},
		'{32'h8000_0000, 32'h5555_5555, 0, 16'sd0, 16'sd0},
		'{32'hAAAA_AAAA, 32'hAAAA_AAAA, 0, 16'sd0, 16'sd0},
		'{32'h7FFF_FFFF, 32'hA000_0000, 0, 16'sd0, 16'sd0},
		'{32'h0000_00FF, 32'h6000_0000, 0, 16'sd0, 16'sd0},
		'{32'hFFFF_0000, 32'h0000_0001, 0, 16'sd0, 16'sd0}
	};

	// ---------------- sender ----------------

	int burst_left;

	task automatic send_pair(input logic [31:0] a, input logic [31:0] b, input bit typed,
			input logic signed [SAMPLE_BITS-1:0] sin_t,
			input logic signed [SAMPLE_BITS-1:0] cos_t);
		logic signed [SAMPLE_BITS-1:0] sin_p;
		logic signed [SAMPLE_BITS-1:0] cos_p;
		int                            gap;
		normal_sample_t                ent;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				uin.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		if (typed) begin
			sin_p = sin_t;
			cos_p = cos_t;
		end else begin
			predict_normal_pair(a, b, sin_p, cos_p);
		end
		uin.valid     <= 1'b1;
		uin.uniform_a <= a;
		uin.uniform_b <= b;
		do
			@(posedge clk);
		while (!uin.ready);
		ent.sample = sin_p;
		ent.last   = 1'b0;
		samples_due.insert(samples_due.size(), ent);
		ent.sample = cos_p;
		ent.last   = 1'b1;
		samples_due.insert(samples_due.size(), ent);
	endtask

	initial begin
		logic [31:0] a;
		logic [31:0] b;
		n_errors      = 0;
		burst_left    = 0;
		arst_n        = 1'b0;
		uin.valid     = 1'b0;
		uin.uniform_a = '0;
		uin.uniform_b = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i])
			send_pair(directed[i].a, directed[i].b, directed[i].typed,
				directed[i].sin_val, directed[i].cos_val);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) begin
				// hold off until the pipeline has fully drained
				uin.valid <= 1'b0;
				while (samples_due.size() != 0)
					@(posedge clk);
			end
			a = $urandom;
			b = $urandom;
			case ($urandom_range(0, 7))
				0: a = $urandom_range(0, 255);
				1: a = 32'hFFFF_FFFF - $urandom_range(0, 255);
				2: b = {b[31:29], 29'd0} + $urandom_range(0, 3) - 2;
				default: ;
			endcase
			send_pair(a, b, 0, '0, '0);
		end
		uin.valid <= 1'b0;
		while (samples_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_errors == 0)
			$display("box_muller_gaussian_tb: done, clean");
		else
			$display("box_muller_gaussian_tb: done, errors");
		$finish;
	end

	// ---------------- sink and checker ----------------

	initial uout.ready = 1'b0;
	initial cycle = 0;

	always @(posedge clk) begin
		cycle <= cycle + 1;
		case ((cycle / 256) % 4)
			0: uout.ready <= 1'b1;
			1: uout.ready <= $urandom_range(0, 1);
			2: uout.ready <= (cycle % 7) >= 3;
			default: uout.ready <= $urandom_range(0, 4) != 0;
		endcase
	end

	always @(posedge clk) begin
		normal_sample_t want;
		if (arst_n && uout.valid && uout.ready) begin
			if (samples_due.size() == 0) begin
				$display("%0t: sample with no request pending, got sample=%0d last=%0b",
					$time, uout.sample, uout.last);
				n_errors++;
			end else begin
				want = samples_due.pop_front();
				if (uout.sample !== want.sample) begin
					$display("%0t: sample mismatch, expected %0d, got %0d",
						$time, want.sample, uout.sample);
					n_errors++;
				end
				if (uout.last !== want.last) begin
					$display("%0t: last mismatch, expected %0b, got %0b",
						$time, want.last, uout.last);
					n_errors++;
				end
			end
		end
	end

	// watchdog: cycles in which neither side moves a request or a sample
	initial idle_cycles = 0;

	always @(posedge clk) begin
		if ((uin.valid && uin.ready) || (uout.valid && uout.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
				$display("box_muller_gaussian_tb: done, errors");
				$finish;
			end
		end
	end

endmodule
`default_nettype wire
